@@ src/qmj_pkg.sv @@
// Shared types and constants for the minimum-jerk trajectory generator.
// No dependencies.
package qmj_pkg;
   localparam int AXES       = 3;
   localparam int POS_W      = 32;
   localparam int TIME_W     = 30;
   localparam int BLEND_BITS = 30;
   localparam int S_W        = BLEND_BITS + 1;
   localparam int INNER_W    = BLEND_BITS + 5;
   localparam int DIFF_W     = POS_W + 1;
   localparam int PROD_W     = DIFF_W + S_W + 1;
   localparam int ADDR_W     = $clog2(2 * AXES + 1);
   localparam int REG_START0   = 0;
   localparam int REG_GOAL0    = AXES;
   localparam int REG_DURATION = 2 * AXES;
   localparam logic [TIME_W-1:0] DURATION_RESET = TIME_W'(1000000);

   typedef struct packed {
      logic valid;
      logic done;
   } ctl_type;

   typedef logic signed [POS_W-1:0] pos_type;
endpackage

@@ src/qmj_div.sv @@
// Bit-per-stage restoring divider: s = floor(t * 2^30 / T), saturated to 1.0.
// Depends on qmj_pkg.
module qmj_div import qmj_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [TIME_W-1:0] elapsed,
   input  logic [TIME_W-1:0] duration,
   output ctl_type           out_ctl,
   output logic [S_W-1:0]    out_s
);
   logic [TIME_W-1:0]     r_ff [BLEND_BITS];
   logic [BLEND_BITS-1:0] q_ff [BLEND_BITS];
   ctl_type               ctl_ff [BLEND_BITS];
   logic                  done;

   assign done = elapsed >= duration;

   for (genvar k = 0; k < BLEND_BITS; k++) begin : g_step
      logic [TIME_W-1:0]     r_src;
      logic [BLEND_BITS-1:0] q_src;
      ctl_type               c_src;
      logic [TIME_W:0]       r2;
      logic                  ge;
      logic [TIME_W:0]       diff;
      if (k == 0) begin : g_first
         assign r_src = done ? '0 : elapsed;
         assign q_src = '0;
         assign c_src = '{valid: in_valid, done: done};
      end else begin : g_next
         assign r_src = r_ff[k-1];
         assign q_src = q_ff[k-1];
         assign c_src = ctl_ff[k-1];
      end
      assign r2   = {r_src, 1'b0};
      assign ge   = r2 >= {1'b0, duration};
      assign diff = r2 - {1'b0, duration};
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k].valid <= 1'b0;
         end else if (en) begin
            ctl_ff[k].valid <= c_src.valid;
         end
         if (en) begin
            ctl_ff[k].done <= c_src.done;
            r_ff[k]        <= ge ? diff[TIME_W-1:0] : r2[TIME_W-1:0];
            q_ff[k]        <= {q_src[BLEND_BITS-2:0], ge};
         end
      end
   end

   assign out_ctl = ctl_ff[BLEND_BITS-1];
   assign out_s   = out_ctl.done ? (S_W'(1) << BLEND_BITS)
                                 : {1'b0, q_ff[BLEND_BITS-1]};
endmodule

@@ src/qmj_blend.sv @@
// Blend polynomial b(s) = 10s^3 - 15s^4 + 6s^5 in Q1.30, four register stages.
// Depends on qmj_pkg.
module qmj_blend import qmj_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  ctl_type        in_ctl,
   input  logic [S_W-1:0] in_s,
   output ctl_type        out_ctl,
   output logic [S_W-1:0] out_b
);
   ctl_type                 c1_ff, c2_ff, c3_ff, c4_ff;
   logic [S_W-1:0]          s1_ff;
   logic [2*S_W-1:0]        ss_ff;
   logic [2*S_W-1:0]        s3p_ff;
   logic [INNER_W-1:0]      inner_ff;
   logic [S_W+INNER_W-1:0]  bp_ff;
   logic [S_W-1:0]          b_ff;
   logic [S_W-1:0]          s2;
   logic [S_W-1:0]          s3;
   logic [INNER_W-1:0]      inner_in;

   assign s2 = ss_ff[BLEND_BITS +: S_W];
   assign s3 = s3p_ff[BLEND_BITS +: S_W];
   assign inner_in = (INNER_W'(10) << BLEND_BITS) + INNER_W'(s2) * INNER_W'(6)
                     - INNER_W'(s1_ff) * INNER_W'(15);

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
         c3_ff.valid <= 1'b0;
         c4_ff.valid <= 1'b0;
      end else if (en) begin
         c1_ff.valid <= in_ctl.valid;
         c2_ff.valid <= c1_ff.valid;
         c3_ff.valid <= c2_ff.valid;
         c4_ff.valid <= c3_ff.valid;
      end
      if (en) begin
         c1_ff.done <= in_ctl.done;
         c2_ff.done <= c1_ff.done;
         c3_ff.done <= c2_ff.done;
         c4_ff.done <= c3_ff.done;
         s1_ff      <= in_s;
         ss_ff      <= in_s * in_s;
         s3p_ff     <= s2 * s1_ff;
         inner_ff   <= inner_in;
         bp_ff      <= s3 * inner_ff;
         b_ff       <= bp_ff[BLEND_BITS +: S_W];
      end
   end

   assign out_ctl = c4_ff;
   assign out_b   = b_ff;
endmodule

@@ src/qmj_scale.sv @@
// Per-axis interpolation pos = start + floor((goal - start) * b / 2^30).
// Depends on qmj_pkg; the last stage is the result register.
module qmj_scale import qmj_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  ctl_type        in_ctl,
   input  logic [S_W-1:0] in_b,
   input  pos_type        start [AXES],
   input  pos_type        goal  [AXES],
   output ctl_type        out_ctl,
   output pos_type        pos   [AXES]
);
   ctl_type c1_ff, c2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
      end else if (en) begin
         c1_ff.valid <= in_ctl.valid;
         c2_ff.valid <= c1_ff.valid;
      end
      if (en) begin
         c1_ff.done <= in_ctl.done;
         c2_ff.done <= c1_ff.done;
      end
   end

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      logic signed [DIFF_W-1:0] diff;
      logic signed [PROD_W-1:0] prod_ff;
      pos_type                  pos_ff;
      assign diff = DIFF_W'(goal[a]) - DIFF_W'(start[a]);
      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff <= diff * $signed({1'b0, in_b});
            pos_ff  <= start[a] + pos_type'(prod_ff[BLEND_BITS +: POS_W]);
         end
      end
      assign pos[a] = pos_ff;
   end

   assign out_ctl = c2_ff;
endmodule

@@ src/quintic_min_jerk_trajectory.sv @@
// Top level of the three-axis minimum-jerk trajectory generator.
// Depends on qmj_pkg, qmj_div, qmj_blend and qmj_scale.
//
// Usage:
//   csr_*  : write port; index 0..2 start x/y/z, 3..5 goal x/y/z (signed
//            Q16.16), 6 duration in us (low 30 bits). Other indexes ignored.
//            Write only while no beat is in flight.
//   req_*  : elapsed time in us, one beat per sample.
//   rsp_*  : desired x/y/z position and finished flag (elapsed >= duration).
// Between the req beat and the rsp beat lie 30 divider stages (one quotient
// bit each), 4 blend polynomial stages and 2 per-axis scale stages;
// rsp_valid is driven by the last scale stage register.
// Throughput one beat per cycle unless stalled. The whole pipeline advances together;
// when rsp_valid is high and rsp_ready low it freezes, req_ready drops,
// and nothing is lost. Reset clears all valid bits, start and goal
// positions to 0 and duration to 1000000 us.
module quintic_min_jerk_trajectory import qmj_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_addr,
   input  logic [POS_W-1:0]  csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [TIME_W-1:0] req_elapsed_us,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [POS_W-1:0]  rsp_pos_x,
   output logic [POS_W-1:0]  rsp_pos_y,
   output logic [POS_W-1:0]  rsp_pos_z,
   output logic              rsp_finished
);
   pos_type           start_ff [AXES];
   pos_type           goal_ff  [AXES];
   logic [TIME_W-1:0] duration_ff;
   logic              en;
   ctl_type           div_ctl, blend_ctl, out_ctl;
   logic [S_W-1:0]    s, b;
   pos_type           pos [AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            start_ff[i] <= '0;
            goal_ff[i]  <= '0;
         end
         duration_ff <= DURATION_RESET;
      end else if (csr_we) begin
         for (int i = 0; i < AXES; i++) begin
            if (csr_addr == ADDR_W'(REG_START0 + i)) begin
               start_ff[i] <= pos_type'(csr_wdata);
            end
            if (csr_addr == ADDR_W'(REG_GOAL0 + i)) begin
               goal_ff[i] <= pos_type'(csr_wdata);
            end
         end
         if (csr_addr == ADDR_W'(REG_DURATION)) begin
            duration_ff <= csr_wdata[TIME_W-1:0];
         end
      end
   end

   assign en        = !out_ctl.valid || rsp_ready;
   assign req_ready = en;

   qmj_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .elapsed  (req_elapsed_us),
      .duration (duration_ff),
      .out_ctl  (div_ctl),
      .out_s    (s)
   );

   qmj_blend u_blend (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_ctl  (div_ctl),
      .in_s    (s),
      .out_ctl (blend_ctl),
      .out_b   (b)
   );

   qmj_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_ctl  (blend_ctl),
      .in_b    (b),
      .start   (start_ff),
      .goal    (goal_ff),
      .out_ctl (out_ctl),
      .pos     (pos)
   );

   assign rsp_valid    = out_ctl.valid;
   assign rsp_finished = out_ctl.done;
   assign rsp_pos_x    = pos[0];
   assign rsp_pos_y    = pos[1];
   assign rsp_pos_z    = pos[2];

   a_finished_at_goal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |->
         rsp_pos_x == goal_ff[0] && rsp_pos_y == goal_ff[1] && rsp_pos_z == goal_ff[2])
      else $error("finished beat not at goal");

   a_ready_follows_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not track output stall");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_finished))
      else $error("result changed during stall");

   a_unfinished_s_below_one: assert property (@(posedge clock) disable iff (reset)
      div_ctl.valid && !div_ctl.done |-> !s[BLEND_BITS])
      else $error("quotient reached one before duration");
endmodule

@@ tb/quintic_min_jerk_trajectory_tb.sv @@
// Testbench for quintic_min_jerk_trajectory: a directed table, then random
// phases of register writes and elapsed-time beats, checked against a predictor.
// Depends on qmj_pkg and the RTL of the block.
`timescale 1ns / 1ps

module quintic_min_jerk_trajectory_tb;
   import qmj_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      logic [POS_W-1:0] pz;
      logic             fin;
   } pose_type;

   typedef struct {
      bit               is_csr;
      bit [ADDR_W-1:0]  addr;
      bit [31:0]        val;
      bit               typed;
      pose_type         want;
   } step_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [ADDR_W-1:0] csr_addr = '0;
   logic [POS_W-1:0]  csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [TIME_W-1:0] req_elapsed_us = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [POS_W-1:0]  rsp_pos_x;
   logic [POS_W-1:0]  rsp_pos_y;
   logic [POS_W-1:0]  rsp_pos_z;
   logic              rsp_finished;

   pos_type           start_r[AXES];
   pos_type           goal_r[AXES];
   logic [TIME_W-1:0] dur_r;
   pose_type          pending_poses[$];
   int                errors = 0;
   bit                quiet = 0;
   int                stall_left = 0;

   localparam logic [31:0] PMIN = 32'h8000_0000;
   localparam logic [31:0] PMAX = 32'h7fff_ffff;
   localparam logic [29:0] TMAX = 30'h3fff_ffff;
   localparam bit [ADDR_W-1:0] BAD_REG = ADDR_W'(REG_DURATION + 1);

   quintic_min_jerk_trajectory dut (.*);

   always #2 clock = ~clock;

   function automatic pose_type plan_pose(logic [TIME_W-1:0] t);
      logic [63:0]        s, s2, s3, inner, b;
      logic signed [63:0] diff, prod;
      logic [POS_W-1:0]   ax[AXES];
      pose_type           p;
      p.fin = (t >= dur_r);
      if (p.fin)
         s = 64'd1 << BLEND_BITS;
      else
         s = ({34'd0, t} << BLEND_BITS) / {34'd0, dur_r};
      s2 = (s * s) >> BLEND_BITS;
      s3 = (s2 * s) >> BLEND_BITS;
      inner = 64'd10 * (64'd1 << BLEND_BITS) + 64'd6 * s2 - 64'd15 * s;
      b = (s3 * inner) >> BLEND_BITS;
      for (int i = 0; i < AXES; i++) begin
         diff = 64'(goal_r[i]) - 64'(start_r[i]);
         prod = diff * $signed(b);
         ax[i] = 32'(64'(start_r[i]) + (prod >>> BLEND_BITS));
      end
      p.px = ax[0];
      p.py = ax[1];
      p.pz = ax[2];
      return p;
   endfunction

   task automatic write_reg(bit [ADDR_W-1:0] addr, bit [31:0] val);
      wait (pending_poses.size() == 0);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= val;
      if (addr < REG_GOAL0)
         start_r[addr] = val;
      else if (addr < REG_DURATION)
         goal_r[addr - REG_GOAL0] = val;
      else if (addr == REG_DURATION)
         dur_r = val[TIME_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_time(logic [TIME_W-1:0] t, bit typed, pose_type want);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_elapsed_us <= t;
      do @(posedge clock); while (!req_ready);
      pending_poses.insert(pending_poses.size(), typed ? want : plan_pose(t));
      @(negedge clock);
   endtask

   task automatic idle_req();
      req_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pose_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_poses.size() == 0) begin
            $error("unexpected beat: pos_x %h", rsp_pos_x);
            errors++;
         end else begin
            w = pending_poses.pop_front();
            if (rsp_pos_x !== w.px) begin
               $error("pos_x expected %h actual %h", w.px, rsp_pos_x);
               errors++;
            end
            if (rsp_pos_y !== w.py) begin
               $error("pos_y expected %h actual %h", w.py, rsp_pos_y);
               errors++;
            end
            if (rsp_pos_z !== w.pz) begin
               $error("pos_z expected %h actual %h", w.pz, rsp_pos_z);
               errors++;
            end
            if (rsp_finished !== w.fin) begin
               $error("finished expected %b actual %b", w.fin, rsp_finished);
               errors++;
            end
         end
      end
   end

   function automatic step_type item(logic [29:0] t, bit typed, pose_type want);
      step_type r;
      r.is_csr = 0;
      r.addr = '0;
      r.val = {2'b0, t};
      r.typed = typed;
      r.want = want;
      return r;
   endfunction

   function automatic step_type reg_row(bit [ADDR_W-1:0] a, bit [31:0] v);
      step_type r;
      r.is_csr = 1;
      r.addr = a;
      r.val = v;
      r.typed = 0;
      r.want = '0;
      return r;
   endfunction

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 5))
         0: return PMIN;
         1: return PMAX;
         2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      step_type          plan[$];
      pose_type          beg, fin0;
      logic [63:0]       hi;
      logic [TIME_W-1:0] t;
      int                n;

      for (int i = 0; i < AXES; i++) begin
         start_r[i] = '0;
         goal_r[i] = '0;
      end
      dur_r = DURATION_RESET;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // after reset: all positions zero, duration 1 s
      plan.insert(plan.size(), item(30'd0, 1, '0));
      plan.insert(plan.size(), item(TMAX, 1, pose_type'(1)));
      plan.insert(plan.size(), item(30'd999999, 1, '0));
      plan.insert(plan.size(), item(30'd1000000, 1, pose_type'(1)));
      plan.insert(plan.size(), reg_row(REG_START0, PMIN));
      plan.insert(plan.size(), reg_row(REG_START0 + 1, PMAX));
      plan.insert(plan.size(), reg_row(REG_START0 + 2, 32'd0));
      plan.insert(plan.size(), reg_row(REG_GOAL0, PMAX));
      plan.insert(plan.size(), reg_row(REG_GOAL0 + 1, PMIN));
      plan.insert(plan.size(), reg_row(REG_GOAL0 + 2, 32'h1234_5678));
      plan.insert(plan.size(), reg_row(REG_DURATION, 32'hc000_03e8));
      beg = '{px: PMIN, py: PMAX, pz: 32'd0, fin: 1'b0};
      fin0 = '{px: PMAX, py: PMIN, pz: 32'h1234_5678, fin: 1'b1};
      plan.insert(plan.size(), item(30'd0, 1, beg));
      plan.insert(plan.size(), item(30'd1000, 1, fin0));
      plan.insert(plan.size(), item(30'd500, 0, '0));
      plan.insert(plan.size(), item(30'd1, 0, '0));
      plan.insert(plan.size(), item(30'd999, 0, '0));
      plan.insert(plan.size(), item(TMAX, 1, fin0));
      plan.insert(plan.size(), reg_row(BAD_REG, 32'hffff_ffff));
      plan.insert(plan.size(), item(30'd250, 0, '0));
      // zero duration
      plan.insert(plan.size(), reg_row(REG_DURATION, 32'd0));
      plan.insert(plan.size(), item(30'd0, 1, fin0));
      plan.insert(plan.size(), reg_row(REG_DURATION, {2'b0, TMAX}));
      plan.insert(plan.size(), item(30'd0, 1, beg));
      plan.insert(plan.size(), item(TMAX - 1, 0, '0));
      plan.insert(plan.size(), item(TMAX, 1, fin0));
      plan.insert(plan.size(), reg_row(REG_DURATION, 32'd1));
      plan.insert(plan.size(), item(30'd0, 1, beg));
      plan.insert(plan.size(), item(30'd1, 1, fin0));

      foreach (plan[k]) begin
         if (plan[k].is_csr) begin
            idle_req();
            write_reg(plan[k].addr, plan[k].val);
         end else begin
            send_time(plan[k].val[TIME_W-1:0], plan[k].typed, plan[k].want);
         end
      end

      for (int ph = 0; ph < 8; ph++) begin
         idle_req();
         for (int a = 0; a < 2 * AXES; a++)
            write_reg(ADDR_W'(a), rand_pos());
         case ($urandom_range(0, 5))
            0: write_reg(REG_DURATION, {2'($urandom_range(0, 3)), 30'd1});
            1: write_reg(REG_DURATION, {2'b11, TMAX});
            2: write_reg(REG_DURATION, $urandom);
            default: write_reg(REG_DURATION, {2'($urandom_range(0, 3)), 30'(
               $urandom_range(2, 5000))});
         endcase
         if ($urandom_range(0, 2) == 0)
            write_reg(BAD_REG, $urandom);
         quiet = (ph >= 6);
         n = 200;
         for (int i = 0; i < n; i++) begin
            hi = (64'(dur_r) * 5) / 4 + 2;
            if (hi > 64'(TMAX))
               hi = 64'(TMAX);
            case ($urandom_range(0, 9))
               0: t = 30'($urandom);
               1: t = dur_r;
               2: t = (dur_r == 0) ? 30'd0 : dur_r - 1;
               default: t = 30'($urandom % 32'(hi + 1));
            endcase
            send_time(t, 0, '0);
         end
      end
      idle_req();

      wait (pending_poses.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end
endmodule

@@ quintic_min_jerk_trajectory.f @@
src/qmj_pkg.sv
src/qmj_div.sv
src/qmj_blend.sv
src/qmj_scale.sv
src/quintic_min_jerk_trajectory.sv
tb/quintic_min_jerk_trajectory_tb.sv
